### design/lstw_pkg.sv
package lstw_pkg;

  // Datapath widths of the rotator.
  localparam int unsigned XW = 36;
  localparam int unsigned ZW = 34;

  // Inverse CORDIC gain in Q0.32.
  localparam logic [31:0] KINV_Q32 = 32'h9B74_EDA8;

  // Configuration register indexes.
  localparam logic [2:0] REG_POSE_X    = 3'd0;
  localparam logic [2:0] REG_POSE_Y    = 3'd1;
  localparam logic [2:0] REG_HEADING   = 3'd2;
  localparam logic [2:0] REG_ANG_START = 3'd3;
  localparam logic [2:0] REG_ANG_STEP  = 3'd4;
  localparam logic [2:0] REG_RANGE_MIN = 3'd5;
  localparam logic [2:0] REG_RANGE_MAX = 3'd6;

  typedef struct packed {
    logic [31:0] pose_x_mm;
    logic [31:0] pose_y_mm;
    logic [31:0] pose_heading;
    logic [31:0] angle_start;
    logic [30:0] angle_step;
    logic [15:0] range_min_mm;
    logic [15:0] range_max_mm;
  } cfg_t;

  typedef struct packed {
    logic                 ok;
    logic                 last;
    logic [1:0]           quad;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] world_x_mm;
    logic signed [31:0] world_y_mm;
    logic               point_valid;
    logic               last_point;
  } point_t;

  // atan(2^-i) in units of 2^-32 turn, rounded.
  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      5'd30: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

### design/lstw_if.sv
interface lstw_beam_if;
  logic        valid;
  logic        ready;
  logic [15:0] beam_index;
  logic [15:0] range_mm;
  logic        range_invalid;
  logic        last_beam;

  modport source (output valid, beam_index, range_mm, range_invalid, last_beam, input ready);
  modport sink (input valid, beam_index, range_mm, range_invalid, last_beam, output ready);
endinterface

interface lstw_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x_mm;
  logic signed [31:0] world_y_mm;
  logic               point_valid;
  logic               last_point;

  modport source (output valid, world_x_mm, world_y_mm, point_valid, last_point, input ready);
  modport sink (input valid, world_x_mm, world_y_mm, point_valid, last_point, output ready);
endinterface

### design/lstw_front.sv
module lstw_front import lstw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  cfg_t        cfg_i,
  input  logic        vld_i,
  input  logic [15:0] beam_index_i,
  input  logic [15:0] range_mm_i,
  input  logic        range_invalid_i,
  input  logic        last_beam_i,
  output logic        vld_o,
  output cell_t       cell_o
);

  logic        a_vld_q;
  logic        a_ok_q, a_ok_d;
  logic        a_last_q;
  logic [31:0] a_prod_q;
  logic [31:0] a_x0_q;
  logic [46:0] prod;
  logic [47:0] scaled;

  logic        b_vld_q;
  cell_t       b_q, b_d;
  logic [31:0] phi, phi_bias, zres;
  logic [1:0]  quad;

  // Stage A: both multiplies and the range filter.
  assign prod   = {31'd0, beam_index_i} * {16'd0, cfg_i.angle_step};
  assign scaled = {32'd0, range_mm_i} * {16'd0, KINV_Q32};
  assign a_ok_d = !range_invalid_i && (range_mm_i >= cfg_i.range_min_mm)
                  && (range_mm_i <= cfg_i.range_max_mm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ok_q   <= a_ok_d;
      a_last_q <= last_beam_i;
      a_prod_q <= prod[31:0];
      a_x0_q   <= scaled[47:16];
    end
  end

  // Stage B: total angle, quadrant and residual.
  assign phi      = cfg_i.pose_heading + cfg_i.angle_start + a_prod_q;
  assign phi_bias = phi + 32'h2000_0000;
  assign quad     = phi_bias[31:30];
  assign zres     = phi - {quad, 30'd0};

  always_comb begin
    b_d      = '0;
    b_d.ok   = a_ok_q;
    b_d.last = a_last_q;
    b_d.quad = quad;
    b_d.x    = signed'({{(XW-32){1'b0}}, a_x0_q});
    b_d.y    = '0;
    b_d.z    = signed'({{(ZW-32){zres[31]}}, zres});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= b_d;
    end
  end

  assign vld_o  = b_vld_q;
  assign cell_o = b_q;

endmodule

### design/lstw_cordic_cell.sv
module lstw_cordic_cell import lstw_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  cell_t cell_i,
  output logic  vld_o,
  output cell_t cell_o
);

  logic                 vld_q;
  cell_t                cell_q, cell_d;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;

  assign dx  = cell_i.y >>> STAGE;
  assign dy  = cell_i.x >>> STAGE;
  assign ang = signed'({{(ZW-32){1'b0}}, atan_lookup(5'(STAGE))});

  // Rotate toward zero residual angle by one micro-rotation.
  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[ZW-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

### design/lstw_finish.sv
module lstw_finish import lstw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  cfg_t   cfg_i,
  input  logic   vld_i,
  input  cell_t  cell_i,
  output logic   vld_o,
  output point_t point_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic signed [XW-1:0] HALF = XW'(32768);
  localparam int unsigned RW = XW - 16;

  logic                 vld_q;
  point_t               point_q, point_d;
  logic signed [XW-1:0] lx, ly, lx_r, ly_r;
  logic signed [RW-1:0] rx, ry;
  logic signed [33:0]   sx, sy;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  // Exact quarter turns undo the quadrant folding done ahead of the rotator.
  always_comb begin
    case (cell_i.quad)
      QUAD_0: begin
        lx = cell_i.x;
        ly = cell_i.y;
      end
      QUAD_1: begin
        lx = -cell_i.y;
        ly = cell_i.x;
      end
      QUAD_2: begin
        lx = -cell_i.x;
        ly = -cell_i.y;
      end
      default: begin
        lx = cell_i.y;
        ly = -cell_i.x;
      end
    endcase
  end

  assign lx_r = (lx + HALF) >>> 16;
  assign ly_r = (ly + HALF) >>> 16;
  assign rx   = lx_r[RW-1:0];
  assign ry   = ly_r[RW-1:0];
  assign sx   = signed'({{2{cfg_i.pose_x_mm[31]}}, cfg_i.pose_x_mm})
                + signed'({{(34-RW){rx[RW-1]}}, rx});
  assign sy   = signed'({{2{cfg_i.pose_y_mm[31]}}, cfg_i.pose_y_mm})
                + signed'({{(34-RW){ry[RW-1]}}, ry});

  always_comb begin
    point_d             = '0;
    point_d.point_valid = cell_i.ok;
    point_d.last_point  = cell_i.last;
    if (cell_i.ok) begin
      point_d.world_x_mm = sat32(sx);
      point_d.world_y_mm = sat32(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_q <= point_d;
    end
  end

  assign vld_o   = vld_q;
  assign point_o = point_q;

endmodule

### design/lidar_scan_to_world_points_core.sv
// Channel   Direction  Role                                   Transaction
// beam_i    in         lidar beam: index, range, flags        valid & ready
// point_o   out        world point: x, y, valid, end of scan  valid & ready
// cfg_*_i   in         register write: enable, index, data    cfg_we_i high
//
// One transaction per cycle is taken in steady flow. On its way to point_o an
// accepted beam passes two front stages, one cell per micro-rotation, the
// finishing stage and the output register. Reset clears all valid flags and
// loads the register reset values. A stall on point_o fills the one-entry skid
// register; only then does beam_i drop ready and the whole pipeline hold.
module lidar_scan_to_world_points_core import lstw_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  lstw_beam_if.sink    beam_i,
  lstw_point_if.source point_o
);

  // The rotator never runs more than 32 micro-rotations.
  localparam int unsigned NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  cfg_t   cfg_q;
  logic   en;
  logic   vld_chain [0:NSTG];
  cell_t  cell_chain [0:NSTG];
  logic   fin_vld;
  point_t fin_point;

  logic   out_vld_q;
  point_t out_q;
  logic   skid_vld_q;
  point_t skid_q;
  logic   out_take;

  // Configuration registers. Writes must arrive only while the pipeline is empty;
  // the user keeps to this, the block does not enforce it. Every stage reads them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pose_x_mm:    32'd0,
                 pose_y_mm:    32'd0,
                 pose_heading: 32'd0,
                 angle_start:  32'd0,
                 angle_step:   31'd0,
                 range_min_mm: 16'd0,
                 range_max_mm: 16'hFFFF};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_POSE_X:    cfg_q.pose_x_mm    <= cfg_wdata_i;
        REG_POSE_Y:    cfg_q.pose_y_mm    <= cfg_wdata_i;
        REG_HEADING:   cfg_q.pose_heading <= cfg_wdata_i;
        REG_ANG_START: cfg_q.angle_start  <= cfg_wdata_i;
        REG_ANG_STEP:  cfg_q.angle_step   <= cfg_wdata_i[30:0];
        REG_RANGE_MIN: cfg_q.range_min_mm <= cfg_wdata_i[15:0];
        REG_RANGE_MAX: cfg_q.range_max_mm <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while the skid register
  // is occupied, which is a registered condition and keeps ready timing short.
  assign en           = !skid_vld_q;
  assign beam_i.ready = en;

  lstw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cfg_i           (cfg_q),
    .vld_i           (beam_i.valid),
    .beam_index_i    (beam_i.beam_index),
    .range_mm_i      (beam_i.range_mm),
    .range_invalid_i (beam_i.range_invalid),
    .last_beam_i     (beam_i.last_beam),
    .vld_o           (vld_chain[0]),
    .cell_o          (cell_chain[0])
  );

  // The row of rotator cells; cell i applies the micro-rotation by atan(2^-i).
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    lstw_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_chain[g]),
      .cell_i (cell_chain[g]),
      .vld_o  (vld_chain[g+1]),
      .cell_o (cell_chain[g+1])
    );
  end

  lstw_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .vld_i   (vld_chain[NSTG]),
    .cell_i  (cell_chain[NSTG]),
    .vld_o   (fin_vld),
    .point_o (fin_point)
  );

  // Output register with a one-entry skid register. A point leaves the
  // finishing stage at every edge where the pipeline moves; it goes to the
  // output register when that is free or being drained, else into the skid.
  assign out_take = out_vld_q && point_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (fin_vld) begin
      if (!out_vld_q || out_take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (fin_vld) begin
      if (!out_vld_q || out_take) begin
        out_q <= fin_point;
      end else begin
        skid_q <= fin_point;
      end
    end
  end

  assign point_o.valid       = out_vld_q;
  assign point_o.world_x_mm  = out_q.world_x_mm;
  assign point_o.world_y_mm  = out_q.world_y_mm;
  assign point_o.point_valid = out_q.point_valid;
  assign point_o.last_point  = out_q.last_point;

`ifndef SYNTHESIS
  // The skid register is used only behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a point while the output register is empty");

  // The skid register fills only after a stalled output.
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !point_o.ready))
    else $error("skid register filled without an output stall");

  // A filtered beam carries zero coordinates.
  a_filtered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && !point_o.point_valid) |->
      (point_o.world_x_mm == 32'sd0 && point_o.world_y_mm == 32'sd0))
    else $error("filtered point has nonzero coordinates");

  // While the skid register is full the output cannot be dropped.
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !point_o.ready) |=> point_o.valid)
    else $error("output dropped while points were queued");
`endif

endmodule
